// File: rtl/core/qoi_image_encoder_macros.svh
// Assertion macros shared by the QOI encoder checker.
// No dependencies.
`ifndef QOI_IMAGE_ENCODER_MACROS_SVH
`define QOI_IMAGE_ENCODER_MACROS_SVH
// plain implication checked on every clock
`define QOI_ASSERT_IMPL(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
	else $error("qoi: %s failed", "label");
// next-cycle implication
`define QOI_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
	else $error("qoi: %s failed", "label");
`endif

// File: rtl/core/qenc_pkg.sv
// Types and constants for the QOI encoder.
// No dependencies.
package qenc_pkg;
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} pixel_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       item_done;
		logic       image_done;
	} byte_out_t;

	// classified pixel passed from front to back
	typedef struct packed {
		logic        hdr;      // emit header first
		logic [7:0]  pre_run;  // run chunk before the pixel code, 0 = none
		logic [2:0]  kind;
		logic [7:0]  b0;
		logic [7:0]  b1;
		logic [31:0] px;
		logic        last;
		logic [7:0]  end_run;  // run flushed at image end, 0 = none
		logic [15:0] width;
		logic [15:0] height;
		logic        four;
	} cmd_t;

	localparam logic [2:0] K_NONE = 3'd0;
	localparam logic [2:0] K_ONE  = 3'd1; // b0
	localparam logic [2:0] K_TWO  = 3'd2; // b0 b1
	localparam logic [2:0] K_RGB  = 3'd3;
	localparam logic [2:0] K_RGBA = 3'd4;

	localparam logic [1:0] REG_CHANNELS = 2'd0;
	localparam logic [1:0] REG_WIDTH    = 2'd1;
	localparam logic [1:0] REG_HEIGHT   = 2'd2;

	localparam logic [7:0] OP_RGB  = 8'hFE;
	localparam logic [7:0] OP_RGBA = 8'hFF;
	localparam logic [5:0] RUN_CAP = 6'd62;
endpackage

// File: rtl/core/qenc_front.sv
// Front end: pixel acceptance, index/run state and chunk classification.
// Depends on qenc_pkg.
module qenc_front import qenc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  pixel_in_t   pix,
	input  logic        four,
	input  logic [15:0] width,
	input  logic [15:0] height,
	output logic        cmd_valid,
	output cmd_t        cmd
);
	logic [31:0] index_q [64];
	logic [63:0] ivalid_q;
	logic [31:0] prev_q;
	logic [5:0]  run_q;
	logic [31:0] count_q;

	// stage 1: accepted pixel plus its registered index lookup
	logic        v_s1;
	logic [31:0] px_s1;
	logic [5:0]  h_s1;
	logic [31:0] rd_s1;
	logic        iv_s1;
	logic        fwd_s1;
	logic [31:0] fpx_s1;
	logic        clr_s1;

	logic [31:0] px_in;
	logic [9:0]  hsum;
	logic [5:0]  h_in;

	logic [31:0] px, hit_val;
	logic [5:0]  h;
	logic        same, last;
	logic [5:0]  run_n;
	logic [7:0]  vr, vg, vb, vgr, vgb;
	logic [31:0] total;

	always_comb begin
		px_in = {(four ? pix.alpha : 8'hFF), pix.blue, pix.green, pix.red};
		hsum = 10'(px_in[7:0] * 3) + 10'(px_in[15:8] * 5) + 10'(px_in[23:16] * 7)
			+ 10'(px_in[31:24] * 11);
		h_in = hsum[5:0];
	end

	always_comb begin
		px = px_s1;
		h = h_s1;
		// the item just ahead wrote or cleared the index in the lookup cycle
		if (clr_s1)
			hit_val = 32'd0;
		else if (fwd_s1)
			hit_val = fpx_s1;
		else
			hit_val = iv_s1 ? rd_s1 : 32'd0;
		same = (px == prev_q);
		total = width * height;
		if (total == 32'd0)
			total = 32'd1;
		last = (count_q + 32'd1) >= total;
		vr = px[7:0] - prev_q[7:0];
		vg = px[15:8] - prev_q[15:8];
		vb = px[23:16] - prev_q[23:16];
		vgr = vr - vg;
		vgb = vb - vg;

		cmd = '0;
		cmd.hdr = (count_q == 32'd0);
		cmd.px = px;
		cmd.last = last;
		cmd.width = width;
		cmd.height = height;
		cmd.four = four;
		cmd.kind = K_NONE;
		run_n = run_q;
		if (same) begin
			run_n = run_q + 6'd1;
			if (run_n == RUN_CAP) begin
				cmd.pre_run = 8'hC0 | 8'(RUN_CAP - 6'd1);
				run_n = '0;
			end
		end else begin
			if (run_q != 6'd0)
				cmd.pre_run = 8'hC0 | 8'(run_q - 6'd1);
			run_n = '0;
			if (hit_val == px) begin
				cmd.kind = K_ONE;
				cmd.b0 = {2'b00, h};
			end else if (four && px[31:24] != prev_q[31:24]) begin
				cmd.kind = K_RGBA;
			end else if ((vr + 8'd2) < 8'd4 && (vg + 8'd2) < 8'd4
					&& (vb + 8'd2) < 8'd4) begin
				cmd.kind = K_ONE;
				cmd.b0 = {2'b01, vr[1:0] + 2'd2, vg[1:0] + 2'd2, vb[1:0] + 2'd2};
			end else if ((vgr + 8'd8) < 8'd16 && (vg + 8'd32) < 8'd64
					&& (vgb + 8'd8) < 8'd16) begin
				cmd.kind = K_TWO;
				cmd.b0 = {2'b10, vg[5:0] + 6'd32};
				cmd.b1 = {vgr[3:0] + 4'd8, vgb[3:0] + 4'd8};
			end else begin
				cmd.kind = K_RGB;
			end
		end
		if (last && run_n != 6'd0)
			cmd.end_run = 8'hC0 | 8'(run_n - 6'd1);
	end

	assign cmd_valid = v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			iv_s1 <= 1'b0;
			fwd_s1 <= 1'b0;
			clr_s1 <= 1'b0;
			ivalid_q <= '0;
			prev_q <= 32'hFF00_0000;
			run_q <= '0;
			count_q <= '0;
		end else begin
			v_s1 <= in_valid;
			iv_s1 <= ivalid_q[h_in];
			fwd_s1 <= v_s1 && (h_s1 == h_in);
			clr_s1 <= v_s1 && last;
			if (v_s1) begin
				if (last) begin
					ivalid_q <= '0;
					prev_q <= 32'hFF00_0000;
					run_q <= '0;
					count_q <= '0;
				end else begin
					ivalid_q[h] <= 1'b1;
					prev_q <= px;
					run_q <= run_n;
					count_q <= count_q + 32'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1)
			index_q[h_s1] <= px_s1;
		rd_s1 <= index_q[h_in];
		fpx_s1 <= px_s1;
		if (in_valid) begin
			px_s1 <= px_in;
			h_s1 <= h_in;
		end
	end
endmodule

// File: rtl/core/qenc_queue.sv
// Short command queue between front and back.
// Depends on qenc_pkg.
module qenc_queue import qenc_pkg::*; #(
	parameter int Depth = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  cmd_t wdata,
	output logic full,
	input  logic rd,
	output cmd_t rdata,
	output logic empty
);
	localparam int AW = $clog2(Depth);
	cmd_t mem_q [Depth];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;

	// a write pending this cycle already holds a slot for the item behind it
	assign full = (cnt_q + (AW+1)'(wr)) >= (AW+1)'(Depth);
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr)
				wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + 1'b1;
			if (rd)
				rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end
endmodule

// File: rtl/core/qenc_back.sv
// Back end: sequences the bytes of one command into the output register.
// Depends on qenc_pkg.
module qenc_back import qenc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_t      cmd,
	input  logic      cmd_avail,
	output logic      cmd_take,
	output logic      empty,
	input  logic      pop,
	output byte_out_t result
);
	// byte slots: 0..13 header, 14 pre-run, 15..19 pixel, 20 end run, 21..28 marker
	localparam logic [4:0] S_PRE = 5'd14;
	localparam logic [4:0] S_PIX = 5'd15;
	localparam logic [4:0] S_END = 5'd20;
	localparam logic [4:0] S_MRK = 5'd21;
	localparam logic [4:0] S_LAST = 5'd28;

	logic [4:0] slot_q;
	logic       busy_q;
	logic       out_v_q;
	byte_out_t  out_q;

	logic       has;
	logic       any;
	logic [7:0] val;
	logic [4:0] first;
	logic [4:0] cur;
	logic [4:0] nxt;
	logic       more;
	logic       load;

	function automatic logic slot_has(input cmd_t c, input logic [4:0] s);
		logic r;
		r = 1'b0;
		if (s < S_PRE)
			r = c.hdr;
		else if (s == S_PRE)
			r = c.pre_run != 8'd0;
		else if (s < S_END)
			case (c.kind)
				K_ONE:   r = (s == S_PIX);
				K_TWO:   r = (s <= S_PIX + 5'd1);
				K_RGB:   r = (s <= S_PIX + 5'd3);
				K_RGBA:  r = 1'b1;
				default: r = 1'b0;
			endcase
		else if (s == S_END)
			r = c.last && c.end_run != 8'd0;
		else
			r = c.last;
		return r;
	endfunction

	always_comb begin
		// empty slots are skipped: a new command starts at its first byte
		first = 5'd0;
		any = 1'b0;
		for (int s = 28; s >= 0; s--)
			if (slot_has(cmd, 5'(s))) begin
				first = 5'(s);
				any = 1'b1;
			end
		cur = busy_q ? slot_q : first;
		has = busy_q || any;
		val = 8'd0;
		case (cur)
			5'd0: val = 8'h71;
			5'd1: val = 8'h6F;
			5'd2: val = 8'h69;
			5'd3: val = 8'h66;
			5'd6: val = cmd.width[15:8];
			5'd7: val = cmd.width[7:0];
			5'd10: val = cmd.height[15:8];
			5'd11: val = cmd.height[7:0];
			5'd12: val = cmd.four ? 8'd4 : 8'd3;
			S_PRE: val = cmd.pre_run;
			S_PIX: val = (cmd.kind == K_RGB) ? OP_RGB : (cmd.kind == K_RGBA) ? OP_RGBA
				: cmd.b0;
			5'd16: val = (cmd.kind == K_TWO) ? cmd.b1 : cmd.px[7:0];
			5'd17: val = cmd.px[15:8];
			5'd18: val = cmd.px[23:16];
			5'd19: val = cmd.px[31:24];
			S_END: val = cmd.end_run;
			S_LAST: val = 8'd1;
			default: val = 8'd0;
		endcase
		nxt = 5'd0;
		more = 1'b0;
		for (int s = 28; s >= 0; s--)
			if (5'(s) > cur && slot_has(cmd, 5'(s))) begin
				nxt = 5'(s);
				more = 1'b1;
			end
		load = cmd_avail && (!out_v_q || pop);
		cmd_take = load && !more;
	end

	assign empty = !out_v_q;
	assign result = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			out_v_q <= 1'b0;
			busy_q <= 1'b0;
		end else begin
			if (pop && out_v_q)
				out_v_q <= 1'b0;
			if (load) begin
				busy_q <= more;
				out_v_q <= has;
				slot_q <= nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.out_byte <= val;
			out_q.item_done <= !more;
			out_q.image_done <= (cur == S_LAST);
		end
	end
endmodule

// File: rtl/core/qoi_image_encoder.sv
// QOI encoder top level: front classifier, command queue, byte sequencer.
// Depends on qenc_pkg, qenc_front, qenc_queue, qenc_back.
// One pixel is accepted per cycle while the command queue has room; the front
// registers the pixel with its color index lookup, then queues a command. The
// back end emits one byte per cycle while the output is popped (header, run,
// chunk, end marker); a pixel holds the byte side until its bytes are out, and
// one that only extends a run still takes a turn there. A pixel's first byte
// passes the front stage register, the queue and the output register. Index
// and diff pixels with no run before them stream one per cycle while popped;
// longer chunks, runs, headers and markers stall input once the queue fills.
module qoi_image_encoder import qenc_pkg::*; #(
	parameter int QueueDepth = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  pixel_in_t   pixel,
	output logic        empty,
	input  logic        pop,
	output byte_out_t   result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	logic [2:0]  chan_q;
	logic [15:0] width_q, height_q;
	cmd_t        fcmd, bcmd;
	logic        fvalid;
	logic        qempty, take, acc;

	assign cfg_ready = 1'b1;
	assign acc = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q <= 3'd4;
			width_q <= 16'd1;
			height_q <= 16'd1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_CHANNELS: chan_q <= cfg_data[2:0];
				REG_WIDTH:    width_q <= cfg_data;
				REG_HEIGHT:   height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	qenc_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(acc), .pix(pixel),
		.four(chan_q != 3'd3), .width(width_q), .height(height_q),
		.cmd_valid(fvalid), .cmd(fcmd)
	);

	qenc_queue #(.Depth(QueueDepth)) u_queue (
		.clk(clk), .arst_n(arst_n), .wr(fvalid), .wdata(fcmd), .full(full),
		.rd(take), .rdata(bcmd), .empty(qempty)
	);

	qenc_back u_back (
		.clk(clk), .arst_n(arst_n), .cmd(bcmd), .cmd_avail(!qempty),
		.cmd_take(take), .empty(empty), .pop(pop), .result(result)
	);
endmodule

// File: rtl/core/qoi_image_encoder_checker.sv
// Port-level checker for the QOI encoder, bound to the top level.
// Depends on qenc_pkg and qoi_image_encoder_macros.svh.
`include "qoi_image_encoder_macros.svh"
module qoi_image_encoder_checker import qenc_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      empty,
	input logic      pop,
	input byte_out_t result
);
	`QOI_ASSERT_IMPL(a_img_item, clk, arst_n, !empty && result.image_done, result.item_done)
	`QOI_ASSERT_IMPL(a_img_byte, clk, arst_n, !empty && result.image_done, result.out_byte == 8'd1)
	`QOI_ASSERT_NEXT(a_hold, clk, arst_n, !empty && !pop, !empty && $stable(result))
endmodule

bind qoi_image_encoder qoi_image_encoder_checker u_checker (
	.clk(clk), .arst_n(arst_n), .empty(empty), .pop(pop), .result(result)
);

// File: tb/qoi_image_encoder_tb.sv
// Self-checking testbench for qoi_image_encoder: streams pixels through the queue ports and
// checks every output byte against a behavioral QOI encoder kept in the testbench.
// Depends on qenc_pkg and the qoi_image_encoder RTL.
`timescale 1ns / 1ps

module qoi_image_encoder_tb;
	import qenc_pkg::*;

	localparam logic [7:0] TAG_DIFF = 8'h40;
	localparam logic [7:0] TAG_LUMA = 8'h80;
	localparam logic [7:0] TAG_RUN  = 8'hC0;
	localparam int DRAIN_CYCLES = 40;
	localparam int QUIET_LIMIT  = 4000;
	localparam int HOLD_CYCLES  = 200;
	localparam int ITEM_TARGET  = 270;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	pixel_in_t   pixel;
	logic        empty;
	logic        pop;
	byte_out_t   result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	qoi_image_encoder DUT (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .pixel(pixel),
		.empty(empty), .pop(pop), .result(result), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// encoder state mirror
	logic [2:0]  chan_reg;
	logic [15:0] width_reg;
	logic [15:0] height_reg;
	logic [31:0] color_tab [64];
	logic [31:0] prev_px;
	int          run_len;
	int          px_count;

	byte_out_t   bytes_due [$];
	int          errors;
	int          quiet;
	bit          calm;
	bit          hold_req;
	int          sent;
	pixel_in_t   last_px;
	pixel_in_t   recent [8];

	typedef struct {
		bit          new_img;
		logic [2:0]  ch;
		logic [15:0] w;
		logic [15:0] h;
		pixel_in_t   px;
		int          n_bytes; // -1: taken from the encoder mirror
	} stim_row_t;

	stim_row_t stim_tab [21];

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic int color_hash(logic [31:0] px);
		return (int'(px[7:0]) * 3 + int'(px[15:8]) * 5 + int'(px[23:16]) * 7
			+ int'(px[31:24]) * 11) % 64;
	endfunction

	function automatic int wrap_diff(logic [7:0] a, logic [7:0] b);
		logic [7:0] d;
		d = a - b;
		return d > 127 ? int'(d) - 256 : int'(d);
	endfunction

	task automatic clear_encoder();
		foreach (color_tab[i]) color_tab[i] = '0;
		prev_px = 32'hFF00_0000;
		run_len = 0;
		px_count = 0;
	endtask

	task automatic encode_pixel(input pixel_in_t p);
		logic [7:0] bq [$];
		logic [31:0] px;
		bit four, ended;
		int h, vr, vg, vb, vgr, vgb;
		longint total;
		byte_out_t r;
		four = chan_reg != 3'd3;
		ended = 0;
		px = {four ? p.alpha : 8'hFF, p.blue, p.green, p.red};
		if (px_count == 0) begin
			bq.push_back("q"); bq.push_back("o"); bq.push_back("i"); bq.push_back("f");
			bq.push_back(8'h00); bq.push_back(8'h00);
			bq.push_back(width_reg[15:8]); bq.push_back(width_reg[7:0]);
			bq.push_back(8'h00); bq.push_back(8'h00);
			bq.push_back(height_reg[15:8]); bq.push_back(height_reg[7:0]);
			bq.push_back(four ? 8'd4 : 8'd3);
			bq.push_back(8'h00);
		end
		if (px == prev_px) begin
			color_tab[color_hash(px)] = px;
			run_len++;
			if (run_len >= RUN_CAP) begin
				bq.push_back(TAG_RUN | (RUN_CAP - 6'd1));
				run_len = 0;
			end
		end else begin
			if (run_len > 0) begin
				bq.push_back(TAG_RUN | 8'(run_len - 1));
				run_len = 0;
			end
			h = color_hash(px);
			if (color_tab[h] == px) begin
				bq.push_back(8'(h));
			end else begin
				color_tab[h] = px;
				vr = wrap_diff(px[7:0], prev_px[7:0]);
				vg = wrap_diff(px[15:8], prev_px[15:8]);
				vb = wrap_diff(px[23:16], prev_px[23:16]);
				vgr = vr - vg;
				vgb = vb - vg;
				if (four && px[31:24] != prev_px[31:24]) begin
					bq.push_back(OP_RGBA);
					bq.push_back(px[7:0]); bq.push_back(px[15:8]);
					bq.push_back(px[23:16]); bq.push_back(px[31:24]);
				end else if (vr > -3 && vr < 2 && vg > -3 && vg < 2 && vb > -3 && vb < 2) begin
					bq.push_back(TAG_DIFF | 8'((vr + 2) << 4 | (vg + 2) << 2 | (vb + 2)));
				end else if (vgr > -9 && vgr < 8 && vg > -33 && vg < 32
						&& vgb > -9 && vgb < 8) begin
					bq.push_back(TAG_LUMA | 8'(vg + 32));
					bq.push_back(8'((vgr + 8) << 4 | (vgb + 8)));
				end else begin
					bq.push_back(OP_RGB);
					bq.push_back(px[7:0]); bq.push_back(px[15:8]); bq.push_back(px[23:16]);
				end
			end
			prev_px = px;
		end
		px_count++;
		total = longint'(width_reg) * longint'(height_reg);
		if (total == 0) total = 1;
		if (px_count >= total) begin
			if (run_len > 0) bq.push_back(TAG_RUN | 8'(run_len - 1));
			repeat (7) bq.push_back(8'h00);
			bq.push_back(8'h01);
			ended = 1;
			clear_encoder();
		end
		foreach (bq[i]) begin
			r.out_byte = bq[i];
			r.item_done = i == bq.size() - 1;
			r.image_done = ended && i == bq.size() - 1;
			bytes_due.push_back(r);
		end
	endtask

	task automatic note_error(input string what);
		if (errors < 10) $display("%0t: %s", $realtime, what);
		errors++;
	endtask

	// byte checker
	always @(posedge clk) begin
		byte_out_t e;
		if (arst_n && pop && !empty) begin
			if (bytes_due.size() == 0) begin
				note_error($sformatf("unexpected byte %h", result.out_byte));
			end else begin
				e = bytes_due.pop_front();
				if (result.out_byte !== e.out_byte || result.item_done !== e.item_done
						|| result.image_done !== e.image_done)
					note_error($sformatf("byte exp %h/%b/%b got %h/%b/%b",
						e.out_byte, e.item_done, e.image_done,
						result.out_byte, result.item_done, result.image_done));
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet > QUIET_LIMIT) begin
			$display("qoi_image_encoder_tb: FAIL");
			$finish;
		end
	end

	// output side
	initial begin
		pop = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 0;
				pop <= 0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				pop <= 0;
				repeat ($urandom_range(0, 13)) @(posedge clk);
			end else begin
				pop <= 1;
			end
		end
	end

	task automatic wait_drained();
		while (bytes_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_CHANNELS: chan_reg = val[2:0];
			REG_WIDTH: width_reg = val;
			REG_HEIGHT: height_reg = val;
			default: ;
		endcase
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	task automatic start_image(input logic [2:0] ch, input logic [15:0] w, input logic [15:0] h);
		push <= 0;
		wait_drained();
		write_reg(REG_CHANNELS, {13'd0, ch});
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
	endtask

	task automatic send_pixel(input pixel_in_t p, input int n_bytes);
		int n_before;
		if (!calm && $urandom_range(0, 7) == 0) begin
			push <= 0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		push <= 1;
		pixel <= p;
		@(posedge clk);
		while (full) @(posedge clk);
		n_before = bytes_due.size();
		encode_pixel(p);
		if (n_bytes >= 0 && bytes_due.size() - n_before != n_bytes)
			note_error($sformatf("pixel %h gives %0d bytes, table says %0d",
				p, bytes_due.size() - n_before, n_bytes));
		last_px = p;
		recent[sent % 8] = p;
		sent++;
	endtask

	function automatic pixel_in_t next_pixel();
		pixel_in_t p;
		p = last_px;
		case ($urandom_range(0, 9))
			0, 1, 2: ;
			3, 4: begin
				p.red += 8'($urandom_range(0, 3) - 2);
				p.green += 8'($urandom_range(0, 3) - 2);
				p.blue += 8'($urandom_range(0, 3) - 2);
			end
			5: begin
				p.green += 8'($urandom_range(0, 63) - 32);
				p.red = p.green + 8'($urandom_range(0, 15) - 8) + (last_px.red - last_px.green);
				p.blue = p.green + 8'($urandom_range(0, 15) - 8) + (last_px.blue - last_px.green);
			end
			6: p = recent[$urandom_range(0, 7)];
			default: begin
				p = pixel_in_t'($urandom);
				if ($urandom_range(0, 1) == 0) p.alpha = last_px.alpha;
			end
		endcase
		return p;
	endfunction

	initial begin
		int npx;
		logic [2:0] ch;
		logic [15:0] w, h;
		pixel_in_t p;
		arst_n = 0;
		push = 0;
		pixel = '0;
		cfg_valid = 0;
		cfg_index = REG_CHANNELS;
		cfg_data = '0;
		errors = 0;
		quiet = 0;
		calm = 0;
		hold_req = 0;
		sent = 0;
		last_px = '0;
		foreach (recent[i]) recent[i] = '0;
		chan_reg = 3'd4;
		width_reg = 16'd1;
		height_reg = 16'd1;
		clear_encoder();

		stim_tab[0]  = '{1, 3'd4, 16'd1, 16'd1, '{8'd0, 8'd0, 8'd0, 8'd255}, 23};
		stim_tab[1]  = '{1, 3'd0, 16'd0, 16'd65535, '{8'd0, 8'd0, 8'd0, 8'd255}, 23};
		stim_tab[2]  = '{1, 3'd7, 16'd65535, 16'd0, '{8'd0, 8'd0, 8'd0, 8'd255}, 23};
		stim_tab[3]  = '{1, 3'd3, 16'd3, 16'd1, '{8'd255, 8'd255, 8'd255, 8'd0}, 15};
		stim_tab[4]  = '{0, 3'd3, 16'd3, 16'd1, '{8'd255, 8'd255, 8'd255, 8'd7}, 0};
		stim_tab[5]  = '{0, 3'd3, 16'd3, 16'd1, '{8'd0, 8'd128, 8'd255, 8'd99}, -1};
		stim_tab[6]  = '{1, 3'd4, 16'd5, 16'd3, '{8'd0, 8'd0, 8'd0, 8'd255}, 14};
		stim_tab[7]  = '{0, 3'd4, 16'd5, 16'd3, '{8'd1, 8'd255, 8'd0, 8'd255}, -1};
		stim_tab[8]  = '{0, 3'd4, 16'd5, 16'd3, '{8'd11, 8'd251, 8'd10, 8'd255}, -1};
		stim_tab[9]  = '{0, 3'd4, 16'd5, 16'd3, '{8'd20, 8'd10, 8'd20, 8'd255}, -1};
		stim_tab[10] = '{0, 3'd4, 16'd5, 16'd3, '{8'd0, 8'd0, 8'd0, 8'd0}, -1};
		stim_tab[11] = '{0, 3'd4, 16'd5, 16'd3, '{8'd0, 8'd0, 8'd0, 8'd0}, 0};
		stim_tab[12] = '{0, 3'd4, 16'd5, 16'd3, '{8'd0, 8'd0, 8'd0, 8'd0}, 0};
		stim_tab[13] = '{0, 3'd4, 16'd5, 16'd3, '{8'd1, 8'd0, 8'd255, 8'd255}, -1};
		stim_tab[14] = '{0, 3'd4, 16'd5, 16'd3, '{8'd0, 8'd0, 8'd0, 8'd0}, -1};
		stim_tab[15] = '{0, 3'd4, 16'd5, 16'd3, '{8'd255, 8'd255, 8'd255, 8'd255}, -1};
		stim_tab[16] = '{0, 3'd4, 16'd5, 16'd3, '{8'd128, 8'd128, 8'd128, 8'd128}, -1};
		stim_tab[17] = '{0, 3'd4, 16'd5, 16'd3, '{8'd127, 8'd128, 8'd129, 8'd128}, -1};
		stim_tab[18] = '{0, 3'd4, 16'd5, 16'd3, '{8'd200, 8'd100, 8'd50, 8'd128}, -1};
		stim_tab[19] = '{0, 3'd4, 16'd5, 16'd3, '{8'd200, 8'd100, 8'd50, 8'd128}, 0};
		stim_tab[20] = '{0, 3'd4, 16'd5, 16'd3, '{8'd255, 8'd0, 8'd255, 8'd1}, -1};

		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (stim_tab[i]) begin
			if (stim_tab[i].new_img) start_image(stim_tab[i].ch, stim_tab[i].w, stim_tab[i].h);
			send_pixel(stim_tab[i].px, stim_tab[i].n_bytes);
		end

		for (int img = 0; sent < ITEM_TARGET; img++) begin
			if (img == 2) begin
				// long flat stretch to hit the run cap, with the output held off
				ch = 3'd3; w = 16'd70; h = 16'd1;
			end else begin
				case ($urandom_range(0, 3))
					0: ch = 3'd3;
					1: ch = 3'd4;
					2: ch = 3'($urandom_range(0, 7));
					default: ch = 3'd4;
				endcase
				w = 16'($urandom_range(1, 8));
				h = 16'($urandom_range(1, 6));
				if ($urandom_range(0, 7) == 0) w = 16'd0;
			end
			if (sent > ITEM_TARGET - 40) calm = 1;
			start_image(ch, w, h);
			npx = int'(w) * int'(h);
			if (npx == 0) npx = 1;
			if (img == 2) hold_req = 1;
			for (int k = 0; k < npx; k++) begin
				if (img == 2) begin
					p = (k == 0 || k == 66) ? pixel_in_t'($urandom) : last_px;
				end else begin
					p = next_pixel();
				end
				send_pixel(p, -1);
			end
		end

		push <= 0;
		while (bytes_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("qoi_image_encoder_tb: PASS");
		else
			$display("qoi_image_encoder_tb: FAIL");
		$finish;
	end
endmodule
